// File: rtl/bde_pkg.sv
package bde_pkg;

  localparam int BDE_NUM_BUTTONS = 4;
  localparam int BDE_BTN_FIELD_W = 4;
  localparam int BDE_HOLD_W = 16;
  localparam int BDE_TIME_W = 32;
  localparam int BDE_SRC_W = 3;
  localparam int BDE_CODE_W = 2;
  localparam int BDE_IN_DATA_W = 40;
  localparam int BDE_OUT_DATA_W = 8;
  localparam int BDE_CFG_IDX_W = 1;

  localparam logic [BDE_HOLD_W-1:0] BDE_BUTTON_HOLD_RST = 16'd50;
  localparam logic [BDE_HOLD_W-1:0] BDE_ENCODER_HOLD_RST = 16'd1;

  localparam logic [BDE_CFG_IDX_W-1:0] CFG_BUTTON_HOLD = 1'd0;
  localparam logic [BDE_CFG_IDX_W-1:0] CFG_ENCODER_HOLD = 1'd1;

  typedef enum logic [5:0] {
    PH_RISE      = 6'b000001,
    PH_HIGH_HOLD = 6'b000010,
    PH_HIGH      = 6'b000100,
    PH_FALL      = 6'b001000,
    PH_LOW_HOLD  = 6'b010000,
    PH_LOW       = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    REP_FALL = 2'd0,
    REP_LOW  = 2'd1,
    REP_RISE = 2'd2,
    REP_HIGH = 2'd3
  } rep_t;

  typedef enum logic [BDE_CODE_W-1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_CW       = 2'd2,
    EV_CCW      = 2'd3
  } event_t;

endpackage

// File: rtl/bde_lane.sv
module bde_lane
  import bde_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  level,
  input  logic [BDE_TIME_W-1:0] now,
  input  logic [BDE_HOLD_W-1:0] hold,
  output rep_t                  rep
);

  phase_t                phase_r, phase_nxt;
  logic [BDE_TIME_W-1:0] deadline_r, deadline_nxt;
  logic [BDE_TIME_W-1:0] due;
  logic                  expired;

  assign due = now + {{(BDE_TIME_W-BDE_HOLD_W){1'b0}}, hold};
  assign expired = now > deadline_r;

  always_comb begin
    phase_nxt = phase_r;
    deadline_nxt = deadline_r;
    rep = REP_HIGH;
    case (phase_r)
      PH_LOW: begin
        if (level) phase_nxt = PH_RISE;
        rep = REP_LOW;
      end
      PH_RISE: begin
        if (level) begin
          phase_nxt = PH_HIGH_HOLD;
          deadline_nxt = due;
          rep = REP_RISE;
        end else begin
          phase_nxt = PH_LOW;
          rep = REP_LOW;
        end
      end
      PH_HIGH_HOLD: begin
        if (expired) phase_nxt = PH_HIGH;
        rep = REP_HIGH;
      end
      PH_HIGH: begin
        if (!level) phase_nxt = PH_FALL;
        rep = REP_HIGH;
      end
      PH_FALL: begin
        if (level) begin
          phase_nxt = PH_HIGH;
          rep = REP_HIGH;
        end else begin
          phase_nxt = PH_LOW_HOLD;
          deadline_nxt = due;
          rep = REP_FALL;
        end
      end
      PH_LOW_HOLD: begin
        if (expired) phase_nxt = PH_LOW;
        rep = REP_LOW;
      end
      default: begin
        phase_nxt = PH_HIGH;
        deadline_nxt = '0;
        rep = REP_HIGH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HIGH;
      deadline_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      deadline_r <= deadline_nxt;
    end
  end

endmodule

// File: rtl/bde_merge.sv
module bde_merge
  import bde_pkg::*;
#(
  parameter int NUM_BUTTONS = BDE_NUM_BUTTONS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rep_t                  reps [NUM_BUTTONS+3],
  output logic                  accept_ok,
  output logic                  ev_valid,
  input  logic                  ev_ready,
  output logic [BDE_SRC_W-1:0]  ev_source,
  output logic [BDE_CODE_W-1:0] ev_code,
  output logic                  ev_last
);

  localparam int NEV = NUM_BUTTONS + 1;
  localparam int IDX_W = $clog2(NEV);

  logic [NEV-1:0]        new_mask;
  logic [BDE_CODE_W-1:0] new_code [NEV];
  logic [NEV-1:0]        head_mask_r, head_mask_nxt, spare_mask_r, spare_mask_nxt;
  logic [BDE_CODE_W-1:0] head_code_r [NEV];
  logic [BDE_CODE_W-1:0] head_code_nxt [NEV];
  logic [BDE_CODE_W-1:0] spare_code_r [NEV];
  logic [BDE_CODE_W-1:0] spare_code_nxt [NEV];
  logic [NEV-1:0]        sel_onehot, head_left;
  logic [IDX_W-1:0]      sel_idx;
  logic                  take;
  rep_t                  rep_a, rep_b, rep_p;

  assign rep_a = reps[NUM_BUTTONS];
  assign rep_b = reps[NUM_BUTTONS+1];
  assign rep_p = reps[NUM_BUTTONS+2];

  // lane reports to event slots
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      new_mask[i] = (reps[i] == REP_FALL) || (reps[i] == REP_RISE);
      new_code[i] = (reps[i] == REP_FALL) ? EV_PRESSED : EV_RELEASED;
    end
    new_mask[NUM_BUTTONS] = (rep_a == REP_FALL) || (rep_p == REP_FALL) || (rep_p == REP_RISE);
    if (rep_a == REP_FALL) begin
      new_code[NUM_BUTTONS] = (rep_b == REP_HIGH) ? EV_CW : EV_CCW;
    end else begin
      new_code[NUM_BUTTONS] = (rep_p == REP_FALL) ? EV_PRESSED : EV_RELEASED;
    end
  end

  // lowest pending event goes first
  always_comb begin
    sel_idx = '0;
    for (int i = NEV - 1; i >= 0; i--) begin
      if (head_mask_r[i]) sel_idx = IDX_W'(i);
    end
    sel_onehot = '0;
    sel_onehot[sel_idx] = head_mask_r[sel_idx];
  end

  assign ev_valid = |head_mask_r;
  assign ev_source = BDE_SRC_W'(sel_idx);
  assign ev_code = head_code_r[sel_idx];
  assign ev_last = (head_mask_r & ~sel_onehot) == '0;
  assign accept_ok = spare_mask_r == '0;
  assign take = ev_valid && ev_ready;
  assign head_left = take ? (head_mask_r & ~sel_onehot) : head_mask_r;

  always_comb begin
    head_mask_nxt = head_left;
    head_code_nxt = head_code_r;
    spare_mask_nxt = spare_mask_r;
    spare_code_nxt = spare_code_r;
    if ((head_left == '0) && (spare_mask_r != '0)) begin
      head_mask_nxt = spare_mask_r;
      head_code_nxt = spare_code_r;
      spare_mask_nxt = '0;
    end
    if (push && (new_mask != '0)) begin
      if (head_mask_nxt == '0) begin
        head_mask_nxt = new_mask;
        head_code_nxt = new_code;
      end else begin
        spare_mask_nxt = new_mask;
        spare_code_nxt = new_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_mask_r <= '0;
      spare_mask_r <= '0;
    end else begin
      head_mask_r <= head_mask_nxt;
      spare_mask_r <= spare_mask_nxt;
    end
    head_code_r <= head_code_nxt;
    spare_code_r <= spare_code_nxt;
  end

endmodule

// File: rtl/button_debounce_and_encoder_events.sv
// Debouncer for a row of buttons and a rotary encoder (A, B, push) with
// press, release and rotation events.
// Input channel in_*: one item per poll carrying raw pin levels and the
// millisecond time. All pins advance together in the same cycle, one debounce
// lane per pin; a merge stage turns lane edges into events.
// Output channel out_*: one item per event, buttons in ascending order, then
// the encoder; tlast marks the final event of a poll. A poll with no edge
// gives no item.
// A poll's events are registered into the draining slot, else the waiting slot.
// Throughput: events leave one per cycle while out_tready is high; a poll
// gives at most NUM_BUTTONS+1 events. Polls can arrive back to back as long
// as the output keeps up, set by the two event slots of the merge stage
// (one draining, one waiting).
// Stall: while out_tready is low the current event holds; a further poll is
// still taken into the waiting slot, and in_tready drops once it is full.
// Reset: all lanes return to settled high, hold times return to 50 ms
// (buttons) and 1 ms (encoder), pending events are discarded.
// cfg_*: write enable, register index and data; 0 button hold, 1 encoder hold.
module button_debounce_and_encoder_events
  import bde_pkg::*;
#(
  parameter int NUM_BUTTONS = BDE_NUM_BUTTONS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // button_levels[3:0], enc_a_level[4], enc_b_level[5], enc_push_level[6], now_ms[38:7]
  input  logic [BDE_IN_DATA_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // source[2:0], event_code[4:3]
  output logic [BDE_OUT_DATA_W-1:0] out_tdata,
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [BDE_CFG_IDX_W-1:0]  cfg_index,
  input  logic [BDE_HOLD_W-1:0]     cfg_wdata
);

  localparam int NUM_UNITS = NUM_BUTTONS + 3;

  logic [BDE_HOLD_W-1:0] button_hold_r, encoder_hold_r;
  logic [BDE_TIME_W-1:0] now;
  logic                  push;
  logic                  accept_ok;
  logic [BDE_SRC_W-1:0]  ev_source;
  logic [BDE_CODE_W-1:0] ev_code;
  logic                  unit_level [NUM_UNITS];
  rep_t                  reps [NUM_UNITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_hold_r <= BDE_BUTTON_HOLD_RST;
      encoder_hold_r <= BDE_ENCODER_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUTTON_HOLD: button_hold_r <= cfg_wdata;
        CFG_ENCODER_HOLD: encoder_hold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign now = in_tdata[BDE_TIME_W+6:7];
  assign in_tready = accept_ok;
  assign push = in_tvalid && in_tready;

  for (genvar i = 0; i < NUM_UNITS; i++) begin : g_lane
    if (i < NUM_BUTTONS) begin : g_btn
      if (i < BDE_BTN_FIELD_W) begin : g_pin
        assign unit_level[i] = in_tdata[i];
      end else begin : g_none
        assign unit_level[i] = 1'b0;
      end
      bde_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (push),
        .level (unit_level[i]),
        .now   (now),
        .hold  (button_hold_r),
        .rep   (reps[i])
      );
    end else begin : g_enc
      assign unit_level[i] = in_tdata[BDE_BTN_FIELD_W + i - NUM_BUTTONS];
      bde_lane u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (push),
        .level (unit_level[i]),
        .now   (now),
        .hold  (encoder_hold_r),
        .rep   (reps[i])
      );
    end
  end

  bde_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .reps      (reps),
    .accept_ok (accept_ok),
    .ev_valid  (out_tvalid),
    .ev_ready  (out_tready),
    .ev_source (ev_source),
    .ev_code   (ev_code),
    .ev_last   (out_tlast)
  );

  assign out_tdata = {{(BDE_OUT_DATA_W-BDE_SRC_W-BDE_CODE_W){1'b0}}, ev_code, ev_source};

endmodule

// File: rtl/bde_checker.sv
module bde_checker
  import bde_pkg::*;
#(
  parameter int NUM_BUTTONS = BDE_NUM_BUTTONS
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [BDE_OUT_DATA_W-1:0] out_tdata,
  input logic                      out_tlast
);

  localparam logic [BDE_SRC_W-1:0] ENC_SRC = BDE_SRC_W'(NUM_BUTTONS);

  // stalled event holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled event changed");

  // a full waiting slot means an event is on offer
  a_busy_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no event pending");

  // a poll's events stay contiguous until tlast
  a_poll_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("poll ended without tlast");

  // buttons only press or release
  a_button_code: assert property (@(posedge clk) disable iff (!rst_n)
    (NUM_BUTTONS < 8) && out_tvalid && (out_tdata[2:0] != ENC_SRC) |-> !out_tdata[4])
    else $error("rotation code on a button event");

endmodule

bind button_debounce_and_encoder_events bde_checker #(
  .NUM_BUTTONS (NUM_BUTTONS)
) u_bde_checker (.*);

// File: tb/sv/tb_top.sv
module tb_top;
  import bde_pkg::*;

  localparam int NUM_LANES = BDE_NUM_BUTTONS + 3;
  localparam int LANE_A = BDE_NUM_BUTTONS;
  localparam int LANE_B = BDE_NUM_BUTTONS + 1;
  localparam int LANE_PUSH = BDE_NUM_BUTTONS + 2;
  localparam logic [BDE_SRC_W-1:0] ENC_SOURCE = BDE_SRC_W'(BDE_NUM_BUTTONS);
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [BDE_BTN_FIELD_W-1:0] buttons;
    logic enc_a;
    logic enc_b;
    logic enc_push;
    logic [BDE_TIME_W-1:0] now;
  } poll_t;

  typedef struct {
    logic [BDE_SRC_W-1:0] source;
    event_t code;
    logic last;
  } pin_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // button_levels[3:0], enc_a_level[4], enc_b_level[5], enc_push_level[6], now_ms[38:7]
  logic [BDE_IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // source[2:0], event_code[4:3]
  logic [BDE_OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [BDE_CFG_IDX_W-1:0] cfg_index = CFG_BUTTON_HOLD;
  logic [BDE_HOLD_W-1:0] cfg_wdata = '0;

  phase_t lane_phase [NUM_LANES];
  logic [BDE_TIME_W-1:0] lane_deadline [NUM_LANES];
  logic [BDE_HOLD_W-1:0] btn_hold;
  logic [BDE_HOLD_W-1:0] enc_hold;
  pin_event_t pending_events [$];
  logic [BDE_TIME_W-1:0] cur_ms;
  bit idle_on = 1'b1;
  int error_count = 0;
  int polls_sent = 0;
  int events_checked = 0;
  int settings_used = 0;
  int stall_cycles = 0;

  button_debounce_and_encoder_events dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic rep_t step_lane(int u, logic lv, logic [BDE_TIME_W-1:0] now,
                                     logic [BDE_HOLD_W-1:0] hold);
    rep_t r;
    case (lane_phase[u])
      PH_LOW: begin
        if (lv) lane_phase[u] = PH_RISE;
        r = REP_LOW;
      end
      PH_RISE: begin
        if (lv) begin
          lane_phase[u] = PH_HIGH_HOLD;
          lane_deadline[u] = now + BDE_TIME_W'(hold);
          r = REP_RISE;
        end else begin
          lane_phase[u] = PH_LOW;
          r = REP_LOW;
        end
      end
      PH_HIGH_HOLD: begin
        if (now > lane_deadline[u]) lane_phase[u] = PH_HIGH;
        r = REP_HIGH;
      end
      PH_HIGH: begin
        if (!lv) lane_phase[u] = PH_FALL;
        r = REP_HIGH;
      end
      PH_FALL: begin
        if (lv) begin
          lane_phase[u] = PH_HIGH;
          r = REP_HIGH;
        end else begin
          lane_phase[u] = PH_LOW_HOLD;
          lane_deadline[u] = now + BDE_TIME_W'(hold);
          r = REP_FALL;
        end
      end
      PH_LOW_HOLD: begin
        if (now > lane_deadline[u]) lane_phase[u] = PH_LOW;
        r = REP_LOW;
      end
      default: begin
        lane_phase[u] = PH_HIGH;
        lane_deadline[u] = '0;
        r = REP_HIGH;
      end
    endcase
    return r;
  endfunction

  function automatic void predict_poll(poll_t p);
    pin_event_t evs [$];
    pin_event_t ev;
    rep_t r, ra, rb, rp;
    logic enc_hit;
    event_t enc_code;
    enc_hit = 1'b0;
    enc_code = EV_PRESSED;
    for (int i = 0; i < BDE_NUM_BUTTONS; i++) begin
      r = step_lane(i, p.buttons[i], p.now, btn_hold);
      if (r == REP_FALL || r == REP_RISE) begin
        ev.source = BDE_SRC_W'(i);
        ev.code = (r == REP_FALL) ? EV_PRESSED : EV_RELEASED;
        ev.last = 1'b0;
        evs.push_back(ev);
      end
    end
    ra = step_lane(LANE_A, p.enc_a, p.now, enc_hold);
    rb = step_lane(LANE_B, p.enc_b, p.now, enc_hold);
    rp = step_lane(LANE_PUSH, p.enc_push, p.now, enc_hold);
    if (rp == REP_FALL) begin
      enc_hit = 1'b1;
      enc_code = EV_PRESSED;
    end else if (rp == REP_RISE) begin
      enc_hit = 1'b1;
      enc_code = EV_RELEASED;
    end
    // rotation wins over the push switch
    if (ra == REP_FALL) begin
      enc_hit = 1'b1;
      enc_code = (rb == REP_HIGH) ? EV_CW : EV_CCW;
    end
    if (enc_hit) begin
      ev.source = ENC_SOURCE;
      ev.code = enc_code;
      ev.last = 1'b0;
      evs.push_back(ev);
    end
    if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endfunction

  task automatic send_poll(input poll_t p);
    while (idle_on && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, p.now, p.enc_push, p.enc_b, p.enc_a, p.buttons};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_poll(p);
    polls_sent++;
  endtask

  task automatic poll_at(input logic [3:0] buttons, input logic a, input logic b,
                         input logic push, input logic [BDE_TIME_W-1:0] now);
    poll_t p;
    p.buttons = buttons;
    p.enc_a = a;
    p.enc_b = b;
    p.enc_push = push;
    p.now = now;
    send_poll(p);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_holds(input logic [BDE_HOLD_W-1:0] b, input logic [BDE_HOLD_W-1:0] e);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BUTTON_HOLD;
    cfg_wdata <= b;
    @(posedge clk);
    btn_hold = b;
    cfg_index <= CFG_ENCODER_HOLD;
    cfg_wdata <= e;
    @(posedge clk);
    enc_hold = e;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // reset hold times: presses, releases, both rotations, push, glitch
  task automatic test_directed_debounce();
    poll_at(4'hF, 1, 1, 1, 32'd100);
    poll_at(4'h0, 1, 1, 1, 32'd101);
    poll_at(4'h0, 1, 1, 1, 32'd102);
    poll_at(4'hF, 1, 1, 1, 32'd120);
    poll_at(4'hF, 1, 1, 1, 32'd153);
    poll_at(4'hF, 1, 1, 1, 32'd154);
    poll_at(4'hF, 1, 1, 1, 32'd155);
    poll_at(4'hF, 0, 1, 1, 32'd160);
    poll_at(4'hF, 0, 1, 1, 32'd161);
    poll_at(4'hF, 1, 0, 1, 32'd170);
    poll_at(4'hF, 1, 0, 1, 32'd171);
    poll_at(4'hF, 1, 0, 0, 32'd180);
    poll_at(4'hE, 1, 0, 0, 32'd181);
    poll_at(4'hF, 1, 0, 0, 32'd182);
    poll_at(4'h5, 0, 0, 1, 32'd230);
    poll_at(4'h5, 0, 0, 1, 32'd231);
    poll_at(4'h5, 1, 0, 1, 32'd240);
  endtask

  // hold extremes with the time counter wrapping
  task automatic test_wrap_and_extremes();
    wait_idle();
    write_holds(16'hFFFF, 16'h0000);
    poll_at(4'hD, 0, 1, 1, 32'hFFFF_FFF0);
    poll_at(4'hD, 0, 1, 1, 32'hFFFF_FFF1);
    poll_at(4'hF, 1, 1, 0, 32'hFFFF_FFF1);
    poll_at(4'hF, 1, 1, 0, 32'hFFFF_FFF2);
    poll_at(4'hF, 1, 1, 0, 32'hFFFF_FFF3);
    poll_at(4'hF, 1, 1, 1, 32'h0000_0004);
    poll_at(4'hF, 1, 1, 1, 32'h0001_0000);
    poll_at(4'hF, 1, 1, 1, 32'h0001_0001);
  endtask

  task automatic test_random_polls(input logic [BDE_HOLD_W-1:0] b,
                                   input logic [BDE_HOLD_W-1:0] e,
                                   input int n_polls, input bit with_idle);
    logic [6:0] steady;
    logic [6:0] raw;
    logic [BDE_TIME_W-1:0] span;
    int r;
    wait_idle();
    write_holds(b, e);
    idle_on = with_idle;
    steady = 7'h7F;
    cur_ms = $urandom;
    span = BDE_TIME_W'((b > e) ? b : e) + 2;
    repeat (n_polls) begin
      for (int i = 0; i < 7; i++)
        if ($urandom_range(99) < 12) steady[i] = ~steady[i];
      raw = steady;
      if ($urandom_range(99) < 10) raw[$urandom_range(6)] ^= 1'b1;
      r = $urandom_range(99);
      if (r < 55) cur_ms += $urandom_range(3);
      else if (r < 90) cur_ms += $urandom_range(span);
      else cur_ms += $urandom;
      poll_at(raw[3:0], raw[4], raw[5], raw[6], cur_ms);
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    pin_event_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected item: source %0d event_code %0d last %0d",
               out_tdata[2:0], out_tdata[4:3], out_tlast);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_tdata[2:0] !== want.source) begin
          $error("source: expected %0d, got %0d", want.source, out_tdata[2:0]);
          error_count++;
        end
        if (out_tdata[4:3] !== want.code) begin
          $error("event_code: expected %0d, got %0d", want.code, out_tdata[4:3]);
          error_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          error_count++;
        end
        events_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int u = 0; u < NUM_LANES; u++) begin
      lane_phase[u] = PH_HIGH;
      lane_deadline[u] = '0;
    end
    btn_hold = BDE_BUTTON_HOLD_RST;
    enc_hold = BDE_ENCODER_HOLD_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_debounce();
    test_wrap_and_extremes();
    test_random_polls(16'd0, 16'd0, 90, 1'b1);
    test_random_polls(16'hFFFF, 16'hFFFF, 50, 1'b1);
    test_random_polls(16'($urandom_range(1, 12)), 16'($urandom_range(0, 6)), 110, 1'b0);
    test_random_polls(16'($urandom_range(0, 80)), 16'($urandom_range(0, 40)), 100, 1'b1);
    wait_idle();
    $display("sent %0d polls, checked %0d events over %0d hold settings",
             polls_sent, events_checked, settings_used + 1);
    $display("covered presses, releases, both rotations, push, glitches and time wrap");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bde_pkg.sv
rtl/bde_lane.sv
rtl/bde_merge.sv
rtl/button_debounce_and_encoder_events.sv
rtl/bde_checker.sv
tb/sv/tb_top.sv
